FILE: sv/pps_pkg.sv
// Shared widths, request and response types and sequencer states for the signed distance block.
`timescale 1ns / 1ps

package pps_pkg;

  // Coordinate format: signed, fixed by the request fields
  localparam int COORD_BITS = 24;

  // Derived widths
  localparam int OP_W   = COORD_BITS + 1;       // coordinate differences
  localparam int ACC_W  = 2 * COORD_BITS + 2;   // products, squared distances
  localparam int MAG_W  = 2 * COORD_BITS + 1;   // |cross product|, edge length squared
  localparam int PR_W   = 2 * MAG_W + 1;        // cross product squared, divider shifter
  localparam int QUO_W  = MAG_W + 1;            // quotient bits
  localparam int ROOT_W = COORD_BITS + 1;       // square root
  localparam int SREM_W = COORD_BITS + 2;       // square root partial remainder
  localparam int OUT_W  = COORD_BITS + 2;       // signed distance
  localparam int CNT_W  = $clog2(ACC_W);

  // Squared distance standing for infinity
  localparam logic [ACC_W-1:0] DIST_INF = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] edge_ax;
    logic signed [COORD_BITS-1:0] edge_ay;
    logic signed [COORD_BITS-1:0] edge_bx;
    logic signed [COORD_BITS-1:0] edge_by;
    logic                         last_edge;
  } pps_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] signed_distance;
    logic                    is_inside;
  } pps_rsp_t;

  typedef enum logic [3:0] {
    PPS_IDLE,
    PPS_LOAD,
    PPS_PROD,
    PPS_DECIDE,
    PPS_SQR,
    PPS_DIV,
    PPS_MERGE,
    PPS_ROOT,
    PPS_PUSH
  } pps_state_t;

endpackage

FILE: sv/point_polygon_signed_distance.sv
// Signed distance from a query point to a polygon outline, one edge per request.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req_data): one request per polygon edge, carrying the query
//   point, the edge end points and a last-edge mark. The user must send every ring's closing edge
//   as a request of its own; the block does not enforce it. req_stall is high while an edge is being worked on.
//   Response channel (rsp_valid / rsp_stall / rsp_data): one response per polygon, after the
//   request marked last_edge. It holds the floor square root of the least squared distance,
//   positive inside and negative outside by the even-odd rule, and the inside bit.
//   Processing (COORD_BITS = 24): each edge runs through the bit-serial product lanes in two
//   rounds of 25 bits. When the point projects inside the edge, the bit-serial squaring of the
//   cross product and the radix-2 divider follow. The last edge adds the square root and the
//   load of the response register. A new edge is taken only after the last one is through.
//   The response register frees the engine: a waiting response stalled by rsp_stall holds
//   steady, and the following polygon's edges are taken meanwhile; only the next response
//   waits for it to go.
//   Reset (rst, synchronous) clears the inside bit, sets the least distance to infinity and
//   drops rsp_valid.
module point_polygon_signed_distance
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  pps_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output pps_rsp_t rsp_data
);

  localparam int LANES    = 5;
  localparam int LANE_DOT = 0;  // (P-A).d
  localparam int LANE_LEN = 1;  // |d|^2
  localparam int LANE_CR  = 2;  // (P-A) x d
  localparam int LANE_RR  = 3;  // |P-A|^2
  localparam int LANE_EE  = 4;  // |P-B|^2

  localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(OP_W - 1);
  localparam logic [CNT_W-1:0] PROD_LAST  = CNT_W'(2 * OP_W - 1);
  localparam logic [CNT_W-1:0] SQR_LAST   = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(ROOT_W - 1);

  pps_state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  // Edge registers
  logic signed [OP_W-1:0] dx, dy, rx, ry, ex, ey;
  logic straddle;
  logic last;

  // Product lanes
  logic signed [ACC_W-1:0] lane_acc [LANES];
  logic signed [ACC_W-1:0] lane_mc  [LANES];
  logic signed [OP_W-1:0]  lane_mp  [LANES];
  logic                    lane_neg [LANES];
  logic signed [OP_W-1:0]  op_mc    [LANES];
  logic signed [OP_W-1:0]  op_mp    [LANES];
  logic                    op_neg   [LANES];
  logic signed [ACC_W-1:0] delta    [LANES];
  logic round_end, second_round;

  // Decision
  logic signed [ACC_W-1:0] dot, cr;
  logic [MAG_W-1:0] len2;
  logic [MAG_W-1:0] cr_mag, mag_cr;
  logic dot_le0, dot_ge, near_a, use_div_now, crosses;
  logic use_div;
  logic [ACC_W-1:0] cand, cand_sel, least_min;

  // Serial square and divider share one shifter
  logic [PR_W-1:0]  pr;
  logic [MAG_W+1:0] sq_sum;
  logic [MAG_W:0]   dv_t, dv_d;
  logic             dv_ge;

  // Square root
  logic [ACC_W-1:0]  sqv;
  logic [SREM_W-1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [SREM_W+1:0] rt_t, rt_trial, rt_d;
  logic              rt_ge;

  logic parity, res_inside;
  logic [ACC_W-1:0] least;
  logic rsp_load;

  // Lane operands: first round on dx-side pairs, second on dy-side pairs
  assign second_round = (state == PPS_PROD);
  assign round_end    = (cnt == ROUND_LAST) || (cnt == PROD_LAST);

  always_comb begin
    if (second_round) begin
      op_mc[LANE_DOT] = ry;  op_mp[LANE_DOT] = dy;  op_neg[LANE_DOT] = 1'b0;
      op_mc[LANE_LEN] = dy;  op_mp[LANE_LEN] = dy;  op_neg[LANE_LEN] = 1'b0;
      op_mc[LANE_CR]  = ry;  op_mp[LANE_CR]  = dx;  op_neg[LANE_CR]  = 1'b1;
      op_mc[LANE_RR]  = ry;  op_mp[LANE_RR]  = ry;  op_neg[LANE_RR]  = 1'b0;
      op_mc[LANE_EE]  = ey;  op_mp[LANE_EE]  = ey;  op_neg[LANE_EE]  = 1'b0;
    end else begin
      op_mc[LANE_DOT] = rx;  op_mp[LANE_DOT] = dx;  op_neg[LANE_DOT] = 1'b0;
      op_mc[LANE_LEN] = dx;  op_mp[LANE_LEN] = dx;  op_neg[LANE_LEN] = 1'b0;
      op_mc[LANE_CR]  = rx;  op_mp[LANE_CR]  = dy;  op_neg[LANE_CR]  = 1'b0;
      op_mc[LANE_RR]  = rx;  op_mp[LANE_RR]  = rx;  op_neg[LANE_RR]  = 1'b0;
      op_mc[LANE_EE]  = ex;  op_mp[LANE_EE]  = ex;  op_neg[LANE_EE]  = 1'b0;
    end
  end

  // Shift-add step per lane; the sign bit of the serial operand has negative weight
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!lane_mp[l][0]) begin
        delta[l] = '0;
      end else if (lane_neg[l] ^ round_end) begin
        delta[l] = -lane_mc[l];
      end else begin
        delta[l] = lane_mc[l];
      end
    end
  end

  // Segment case and crossing decision
  assign dot  = lane_acc[LANE_DOT];
  assign cr   = lane_acc[LANE_CR];
  assign len2 = lane_acc[LANE_LEN][MAG_W-1:0];

  always_comb begin
    cr_mag  = cr[ACC_W-1] ? MAG_W'(-cr) : cr[MAG_W-1:0];
    // a degenerate edge gives dot = 0 and lands here too
    dot_le0 = dot[ACC_W-1] || (dot == '0);
    dot_ge  = !dot[ACC_W-1] && ($unsigned(dot) >= ACC_W'(len2));
    near_a  = dot_le0;
    use_div_now = !dot_le0 && !dot_ge;
    // edge goes upward: crossing when the cross product is negative, else positive
    if (dy[OP_W-1]) begin
      crosses = straddle && !cr[ACC_W-1] && (cr != '0);
    end else begin
      crosses = straddle && cr[ACC_W-1];
    end
  end

  // Serial squaring step and restoring division step
  always_comb begin
    sq_sum = {1'b0, pr[PR_W-1:MAG_W]} + (pr[0] ? (MAG_W+2)'(mag_cr) : '0);
    dv_t   = {pr[PR_W-1:QUO_W], pr[QUO_W-1]};
    dv_ge  = dv_t >= (MAG_W+1)'(len2);
    dv_d   = dv_t - (MAG_W+1)'(len2);
  end

  // Minimum update
  assign cand_sel  = use_div ? pr[QUO_W-1:0] : cand;
  assign least_min = (cand_sel < least) ? cand_sel : least;

  // Square root digit step
  always_comb begin
    rt_t     = {srem, sqv[ACC_W-1 -: 2]};
    rt_trial = (SREM_W+2)'({root, 2'b01});
    rt_ge    = rt_t >= rt_trial;
    rt_d     = rt_t - rt_trial;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      PPS_IDLE:   if (req_valid) state_next = PPS_LOAD;
      PPS_LOAD:   state_next = PPS_PROD;
      PPS_PROD:   if (cnt == PROD_LAST) state_next = PPS_DECIDE;
      PPS_DECIDE: state_next = use_div_now ? PPS_SQR : PPS_MERGE;
      PPS_SQR:    if (cnt == SQR_LAST) state_next = PPS_DIV;
      PPS_DIV:    if (cnt == DIV_LAST) state_next = PPS_MERGE;
      PPS_MERGE:  state_next = last ? PPS_ROOT : PPS_IDLE;
      PPS_ROOT:   if (cnt == ROOT_LAST) state_next = PPS_PUSH;
      PPS_PUSH:   if (rsp_load) state_next = PPS_IDLE;
      default:    state_next = PPS_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_stall = (state != PPS_IDLE);
    rsp_load  = (state == PPS_PUSH) && (!rsp_valid || !rsp_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PPS_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CNT_W'(1);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Polygon state: inside bit and least squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      least  <= DIST_INF;
    end else if (state == PPS_DECIDE) begin
      if (crosses) parity <= !parity;
    end else if (state == PPS_MERGE) begin
      if (last) begin
        parity <= 1'b0;
        least  <= DIST_INF;
      end else begin
        least <= least_min;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      PPS_IDLE: begin
        dx <= OP_W'(req_data.edge_bx) - OP_W'(req_data.edge_ax);
        dy <= OP_W'(req_data.edge_by) - OP_W'(req_data.edge_ay);
        rx <= OP_W'(req_data.query_x) - OP_W'(req_data.edge_ax);
        ry <= OP_W'(req_data.query_y) - OP_W'(req_data.edge_ay);
        ex <= OP_W'(req_data.query_x) - OP_W'(req_data.edge_bx);
        ey <= OP_W'(req_data.query_y) - OP_W'(req_data.edge_by);
        straddle <= (req_data.edge_ay > req_data.query_y) !=
                    (req_data.edge_by > req_data.query_y);
        last <= req_data.last_edge;
      end
      PPS_LOAD: begin
        for (int l = 0; l < LANES; l++) begin
          lane_acc[l] <= '0;
          lane_mc[l]  <= ACC_W'(op_mc[l]);
          lane_mp[l]  <= op_mp[l];
          lane_neg[l] <= op_neg[l];
        end
      end
      PPS_PROD: begin
        for (int l = 0; l < LANES; l++) begin
          lane_acc[l] <= lane_acc[l] + delta[l];
          if (cnt == ROUND_LAST) begin
            lane_mc[l]  <= ACC_W'(op_mc[l]);
            lane_mp[l]  <= op_mp[l];
            lane_neg[l] <= op_neg[l];
          end else begin
            lane_mc[l] <= lane_mc[l] <<< 1;
            lane_mp[l] <= lane_mp[l] >>> 1;
          end
        end
      end
      PPS_DECIDE: begin
        cand    <= near_a ? $unsigned(lane_acc[LANE_RR]) : $unsigned(lane_acc[LANE_EE]);
        use_div <= use_div_now;
        mag_cr  <= cr_mag;
        pr      <= PR_W'(cr_mag);
      end
      PPS_SQR: begin
        pr <= {sq_sum, pr[MAG_W-1:1]};
      end
      PPS_DIV: begin
        pr <= {(dv_ge ? dv_d[MAG_W-1:0] : dv_t[MAG_W-1:0]), pr[QUO_W-2:0], dv_ge};
      end
      PPS_MERGE: begin
        sqv        <= least_min;
        srem       <= '0;
        root       <= '0;
        res_inside <= parity;
      end
      PPS_ROOT: begin
        sqv  <= {sqv[ACC_W-3:0], 2'b00};
        srem <= rt_ge ? rt_d[SREM_W-1:0] : rt_t[SREM_W-1:0];
        root <= {root[ROOT_W-2:0], rt_ge};
      end
      PPS_PUSH: begin
        if (rsp_load) begin
          rsp_data.signed_distance <= res_inside ? $signed({1'b0, root})
                                                 : -$signed({1'b0, root});
          rsp_data.is_inside       <= res_inside;
        end
      end
      default: begin
      end
    endcase
  end

  // Polygon state is cleared once the last edge has been merged
  a_root_clears_state: assert property (@(posedge clk) disable iff (rst)
    (state == PPS_ROOT) |-> ((least == DIST_INF) && !parity))
    else $error("polygon state not cleared during square root");

  // Divider remainder stays below the edge length squared
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == PPS_DIV) |-> (pr[PR_W-1:QUO_W] < len2))
    else $error("divider remainder out of range");

  // A response appears only from the push state
  a_rsp_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == PPS_PUSH))
    else $error("response raised outside push state");

  // No request is taken while an edge is in progress
  a_one_edge: assert property (@(posedge clk) disable iff (rst)
    (state != PPS_IDLE) |-> req_stall)
    else $error("request accepted while busy");

endmodule

FILE: tb/sv/pps_result_checker.sv
// Checker for the signed distance block: follows both channels, predicts each response, compares.
`timescale 1ns / 1ps

module pps_result_checker
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  pps_req_t req_data,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  pps_rsp_t rsp_data,
  output int       failures,
  output int       outstanding
);

  // Running polygon state
  logic             inside_bit;
  logic [ACC_W-1:0] nearest_sq;

  // Responses still owed by the block, oldest first
  pps_rsp_t expected_rsp[$];

  initial begin
    failures    = 0;
    outstanding = 0;
    inside_bit  = 1'b0;
    nearest_sq  = DIST_INF;
  end

  task automatic report_mismatch(input string msg);
    failures++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Even-odd test: does a ray from the query point towards +x cross this edge?
  function automatic bit crosses_ray(input pps_req_t r);
    longint px, py, ax, ay, bx, by, lhs, rhs;
    px = r.query_x;
    py = r.query_y;
    ax = r.edge_ax;
    ay = r.edge_ay;
    bx = r.edge_bx;
    by = r.edge_by;
    if ((ay > py) == (by > py)) return 1'b0;
    lhs = (px - ax) * (by - ay);
    rhs = (bx - ax) * (py - ay);
    return (by - ay) > 0 ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Squared distance from the query point to the segment, truncated where it divides
  function automatic logic [ACC_W-1:0] edge_sq_distance(input pps_req_t r);
    longint            px, py, ax, ay, bx, by, dx, dy, rx, ry, dotp, len2, crs;
    longint unsigned   crs_mag;
    logic [127:0]      crs_sq, quot;
    px = r.query_x;
    py = r.query_y;
    ax = r.edge_ax;
    ay = r.edge_ay;
    bx = r.edge_bx;
    by = r.edge_by;
    dx = bx - ax;
    dy = by - ay;
    rx = px - ax;
    ry = py - ay;
    // Zero-length edge: distance to its start point
    if (dx == 0 && dy == 0) return ACC_W'(rx * rx + ry * ry);
    dotp = rx * dx + ry * dy;
    len2 = dx * dx + dy * dy;
    if (dotp <= 0) return ACC_W'(rx * rx + ry * ry);
    if (dotp >= len2) return ACC_W'((px - bx) * (px - bx) + (py - by) * (py - by));
    // Projection falls inside: cross product squared over length squared
    crs     = rx * dy - ry * dx;
    crs_mag = (crs < 0) ? -crs : crs;
    crs_sq  = 128'(crs_mag) * 128'(crs_mag);
    quot    = crs_sq / 128'(len2);
    return quot[ACC_W-1:0];
  endfunction

  // Floor square root, digit by digit
  function automatic logic [ROOT_W-1:0] floor_root(input logic [ACC_W-1:0] v);
    longint unsigned rem, root, bitv;
    rem  = v;
    root = 0;
    bitv = 64'd1 << (2 * ((ACC_W - 1) / 2));
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return ROOT_W'(root);
  endfunction

  // Fold one accepted edge into the polygon state; the last edge yields a response
  task automatic absorb_edge(input pps_req_t r);
    logic [ACC_W-1:0] sq;
    pps_rsp_t         rsp;
    if (crosses_ray(r)) inside_bit = ~inside_bit;
    sq = edge_sq_distance(r);
    if (sq < nearest_sq) nearest_sq = sq;
    if (r.last_edge) begin
      rsp.signed_distance = OUT_W'(floor_root(nearest_sq));
      if (!inside_bit) rsp.signed_distance = -rsp.signed_distance;
      rsp.is_inside = inside_bit;
      expected_rsp.push_back(rsp);
      inside_bit = 1'b0;
      nearest_sq = DIST_INF;
    end
  endtask

  task automatic check_response(input pps_rsp_t got);
    pps_rsp_t want;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("response %0d/%0b with none outstanding",
                                got.signed_distance, got.is_inside));
      return;
    end
    want = expected_rsp.pop_front();
    if (got.signed_distance !== want.signed_distance)
      report_mismatch($sformatf("signed_distance %0d, expected %0d",
                                got.signed_distance, want.signed_distance));
    if (got.is_inside !== want.is_inside)
      report_mismatch($sformatf("is_inside %0b, expected %0b", got.is_inside, want.is_inside));
  endtask

  // Sample both channels at the clock edge, responses before requests
  always @(posedge clk) begin
    if (rst) begin
      inside_bit = 1'b0;
      nearest_sq = DIST_INF;
      expected_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_response(rsp_data);
      if (req_valid && !req_stall) absorb_edge(req_data);
    end
    outstanding <= expected_rsp.size();
  end

endmodule

FILE: tb/sv/tb_point_polygon_signed_distance.sv
// Testbench top for the signed distance block: clock, reset, polygon stimulus and verdict.
`timescale 1ns / 1ps

module tb_point_polygon_signed_distance;
  import pps_pkg::*;

  localparam int     RANDOM_REQUESTS = 700;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  pps_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  pps_rsp_t rsp_data;

  int failures;
  int outstanding;
  int send_idle_pct = 13;
  int rsp_idle_pct  = 57;
  int requests_sent = 0;

  // Vertex store for up to two rings
  longint ring_x[16];
  longint ring_y[16];

  point_polygon_signed_distance uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  pps_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #(64'd20_000_000);
    $display("Verification failed");
    $finish;
  end

  // Response side back-pressure
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
  end

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD_BITS-1:0] c;
    c = COORD_BITS'($urandom);
    return c;
  endfunction

  function automatic pps_req_t make_req(input longint qx, qy, ax, ay, bx, by, input bit last);
    pps_req_t r;
    r.query_x   = COORD_BITS'(qx);
    r.query_y   = COORD_BITS'(qy);
    r.edge_ax   = COORD_BITS'(ax);
    r.edge_ay   = COORD_BITS'(ay);
    r.edge_bx   = COORD_BITS'(bx);
    r.edge_by   = COORD_BITS'(by);
    r.last_edge = last;
    return r;
  endfunction

  // One request, after a random number of idle cycles
  task automatic send_request(input pps_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Edges of one ring from the vertex store; an open ring leaves out its closing edge
  task automatic send_ring(input longint qx, qy, input int first, n,
                           input bit last_ring, open_ring);
    int i, count, j;
    count = open_ring ? n - 1 : n;
    for (i = 0; i < count; i++) begin
      j = first + (i + 1) % n;
      send_request(make_req(qx, qy, ring_x[first + i], ring_y[first + i],
                            ring_x[j], ring_y[j], last_ring && (i == count - 1)));
    end
  endtask

  // Hold the sender off until every response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random polygon of one or two rings around a random centre, queried at a chosen spot
  task automatic send_random_polygon();
    int     rings, n0, n1, k, mode, flaw;
    longint span, cx, cy, qx, qy, qx2, qy2;
    span  = longint'(1) << $urandom_range(3, COORD_BITS - 1);
    cx    = rand_coord();
    cy    = rand_coord();
    rings = ($urandom_range(3) == 0) ? 2 : 1;
    n0    = $urandom_range(3, 8);
    n1    = (rings == 2) ? $urandom_range(3, 8) : 0;
    for (k = 0; k < n0 + n1; k++) begin
      ring_x[k] = clamp_coord(cx + longint'($urandom_range(2 * span)) - span);
      ring_y[k] = clamp_coord(cy + longint'($urandom_range(2 * span)) - span);
    end
    k    = $urandom_range(n0 - 1);
    mode = $urandom_range(5);
    case (mode)
      2: begin
        // on a vertex
        qx = ring_x[k];
        qy = ring_y[k];
      end
      3: begin
        // level with a vertex, so the ray grazes it
        qx = clamp_coord(cx + longint'($urandom_range(2 * span)) - span);
        qy = ring_y[k];
      end
      4: begin
        // halfway along an edge
        qx = (ring_x[k] + ring_x[(k + 1) % n0]) >>> 1;
        qy = (ring_y[k] + ring_y[(k + 1) % n0]) >>> 1;
      end
      5: begin
        qx = rand_coord();
        qy = rand_coord();
      end
      default: begin
        qx = clamp_coord(cx + longint'($urandom_range(2 * span)) - span);
        qy = clamp_coord(cy + longint'($urandom_range(2 * span)) - span);
      end
    endcase
    // Occasional malformed outline: missing closing edge or a query that moves
    flaw = $urandom_range(19);
    qx2  = (flaw == 1) ? rand_coord() : qx;
    qy2  = (flaw == 1) ? rand_coord() : qy;
    send_ring(qx, qy, 0, n0, rings == 1, flaw == 0 && rings == 1);
    if (rings == 2) send_ring(qx2, qy2, n0, n1, 1'b1, flaw == 0);
  endtask

  // Short bursts of fully random edges
  task automatic send_noise();
    int       n, i;
    pps_req_t r;
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      r = make_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), i == n - 1);
      if ($urandom_range(7) == 0) begin
        r.edge_bx = r.edge_ax;
        r.edge_by = r.edge_ay;
      end
      send_request(r);
    end
  endtask

  initial begin
    int base, phase, k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lone zero-length edges: zero distance outside, then the largest distance
    send_request(make_req(0, 0, 0, 0, 0, 0, 1'b1));
    send_request(make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 1'b1));
    // Projection lands on the start of a full-length edge
    send_request(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MAX, 1'b1));

    // Square of side 1024: inside, beyond a corner, level with a vertex, on a vertex
    for (k = 0; k < 4; k++) begin
      ring_x[k] = (k == 1 || k == 2) ? 1024 : 0;
      ring_y[k] = (k >= 2) ? 1024 : 0;
    end
    send_ring(512, 300, 0, 4, 1'b1, 1'b0);
    send_ring(-300, -200, 0, 4, 1'b1, 1'b0);
    send_ring(-300, 1024, 0, 4, 1'b1, 1'b0);
    send_ring(1024, 1024, 0, 4, 1'b1, 1'b0);

    // Full-range triangle: widest cross products and division
    ring_x[0] = COORD_MIN;
    ring_y[0] = COORD_MIN;
    ring_x[1] = COORD_MAX;
    ring_y[1] = COORD_MIN;
    ring_x[2] = 0;
    ring_y[2] = COORD_MAX;
    send_ring(0, 0, 0, 3, 1'b1, 1'b0);
    send_ring(COORD_MAX, COORD_MAX, 0, 3, 1'b1, 1'b0);

    // Zero-length edge mid-polygon, then a long horizontal last edge
    send_request(make_req(5, -7, 5, -7, 5, -7, 1'b0));
    send_request(make_req(5, -7, COORD_MIN, 0, COORD_MAX, 0, 1'b1));

    wait_drained();

    // Random polygons in three idling regimes
    base = requests_sent;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 57 : 0;
      rsp_idle_pct  = (phase == 0) ? 57 : (phase == 1) ? 13 : 0;
      while (requests_sent - base < (phase + 1) * RANDOM_REQUESTS / 3) begin
        if ($urandom_range(9) < 8) send_random_polygon();
        else send_noise();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pps_pkg.sv
sv/point_polygon_signed_distance.sv
tb/sv/pps_result_checker.sv
tb/sv/tb_point_polygon_signed_distance.sv
